// ===== design/tet_pkg.sv =====
// Shared types, constants and codes of the timed event table.
package tet_pkg;

  // Table geometry and field widths
  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned TIME_W    = 32;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_QUERY  = 2'd3
  } tet_action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2
  } tet_status_e;

  typedef struct packed {
    tet_action_e        action;
    logic [ID_W-1:0]    slot_id;
    logic [TIME_W-1:0]  begin_time;
    logic [TIME_W-1:0]  length_ticks;
    logic               start_enable;
    logic               stop_enable;
    logic [TIME_W-1:0]  now_time;
  } tet_req_t;

  typedef struct packed {
    tet_status_e        status;
    logic               is_registered;
    logic [SLOT_W-1:0]  free_slot;
    logic               free_found;
    logic [SLOT_W-1:0]  fired_slot;
    logic               start_fired;
    logic               stop_fired;
    logic               last;
  } tet_rsp_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [TIME_W-1:0]  begin_at;
    logic [TIME_W-1:0]  duration;
    logic               start_flag;
    logic               stop_flag;
  } tet_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_req;
    logic scan_run;
    logic search_run;
    logic flush;
  } tet_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic search_done;
    logic flush_done;
  } tet_stat_t;

endpackage

// ===== design/tet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tet_ctrl.sv =====
// Controller state machine of the timed event table.
module tet_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  tet_pkg::tet_action_e action_i,
  output logic                 in_stall_o,
  input  tet_pkg::tet_stat_t   stat_i,
  output tet_pkg::tet_cmd_t    cmd_o
);
  import tet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FLUSH  = 4'b1000
  } tet_state_e;

  tet_state_e state_q, state_d;
  logic       take;

  // Accept a request only when idle and the output register can take a result
  assign take       = in_valid_i && (state_q == S_IDLE) && stat_i.out_free;
  assign in_stall_o = !((state_q == S_IDLE) && stat_i.out_free);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.take_req   = take;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (action_i)
            ACT_TICK:   state_d = S_SCAN;
            ACT_QUERY:  state_d = S_SEARCH;
            ACT_CREATE: state_d = S_IDLE;
            ACT_DELETE: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_FLUSH;
        end
      end
      S_SEARCH: begin
        cmd_o.search_run = 1'b1;
        if (stat_i.search_done) begin
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (stat_i.flush_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/tet_dp.sv =====
// Datapath of the timed event table: valid marks, entry memory, scan and output.
module tet_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tet_pkg::tet_cmd_t cmd_i,
  output tet_pkg::tet_stat_t stat_o,
  input  tet_pkg::tet_req_t in_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output tet_pkg::tet_rsp_t out_data_o
);
  import tet_pkg::*;

  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ID_W-1:0]      req_id_q, req_id_d;
  logic [TIME_W-1:0]    req_now_q, req_now_d;
  logic [CNT_W-1:0]     issue_q, issue_d;
  logic                 cmp_valid_q, cmp_valid_d;
  logic [SLOT_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [SLOT_W-1:0]    srch_q, srch_d;
  logic                 pend_valid_q, pend_valid_d;
  tet_rsp_t             pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  tet_rsp_t             out_q, out_d;

  logic                 ram_we, ram_re;
  logic [SLOT_W-1:0]    ram_raddr;
  tet_entry_t           ram_wdata, ram_rdata;

  logic                 id_ok, req_id_ok;
  logic [SLOT_W-1:0]    req_idx;
  logic                 out_free;
  logic [TIME_W-1:0]    stop_time;
  logic                 smatch, pmatch, cmp_hit, scan_hold;
  logic                 srch_free, srch_end;
  tet_rsp_t             hit_rsp, qry_rsp;

  // Entry memory: start time, duration and action flags
  tet_ram #(
    .WIDTH ($bits(tet_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign id_ok     = in_data_i.slot_id < ID_W'(NUM_SLOTS);
  assign req_idx   = in_data_i.slot_id[SLOT_W-1:0];
  assign req_id_ok = req_id_q < ID_W'(NUM_SLOTS);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign ram_raddr = issue_q[SLOT_W-1:0];

  assign ram_wdata.begin_at   = in_data_i.begin_time;
  assign ram_wdata.duration   = in_data_i.length_ticks;
  assign ram_wdata.start_flag = in_data_i.start_enable;
  assign ram_wdata.stop_flag  = in_data_i.stop_enable;

  // Compare the registered entry read data against the tick time
  assign stop_time = ram_rdata.begin_at + ram_rdata.duration;
  assign smatch    = ram_rdata.begin_at == req_now_q;
  assign pmatch    = stop_time == req_now_q;
  assign cmp_hit   = cmp_valid_q && valid_q[cmp_idx_q] && (smatch || pmatch);
  // A new hit needs the pending result moved out first
  assign scan_hold = cmp_hit && pend_valid_q && !out_free;

  always_comb begin
    hit_rsp             = '0;
    hit_rsp.status      = ST_OK;
    hit_rsp.fired_slot  = cmp_idx_q;
    hit_rsp.start_fired = smatch && ram_rdata.start_flag;
    hit_rsp.stop_fired  = pmatch && ram_rdata.stop_flag;
  end

  // Walk the valid marks for the lowest free index
  assign srch_free = !valid_q[srch_q];
  assign srch_end  = srch_free || (srch_q == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    qry_rsp               = '0;
    qry_rsp.status        = req_id_ok ? ST_OK : ST_BAD_ID;
    qry_rsp.is_registered = req_id_ok && valid_q[req_id_q[SLOT_W-1:0]];
    qry_rsp.free_slot     = srch_free ? srch_q : '0;
    qry_rsp.free_found    = srch_free;
    qry_rsp.last          = 1'b1;
  end

  always_comb begin
    valid_d      = valid_q;
    count_d      = count_q;
    req_id_d     = req_id_q;
    req_now_d    = req_now_q;
    issue_d      = issue_q;
    cmp_valid_d  = cmp_valid_q;
    cmp_idx_d    = cmp_idx_q;
    srch_d       = srch_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    stat_o       = '0;

    stat_o.out_free   = out_free;
    stat_o.scan_done  = (issue_q == CNT_W'(NUM_SLOTS)) && !cmp_valid_q;
    stat_o.flush_done = !pend_valid_q || out_free;

    // Take a request: create and delete finish here
    if (cmd_i.take_req) begin
      req_id_d     = in_data_i.slot_id;
      req_now_d    = in_data_i.now_time;
      issue_d      = '0;
      cmp_valid_d  = 1'b0;
      srch_d       = '0;
      pend_valid_d = 1'b0;
      unique case (in_data_i.action)
        ACT_CREATE: begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          if (count_q >= CNT_W'(NUM_SLOTS)) begin
            out_d.status = ST_FULL;
          end else if (!id_ok) begin
            out_d.status = ST_BAD_ID;
          end else begin
            out_d.status = ST_OK;
            if (!valid_q[req_idx]) begin
              count_d = count_q + CNT_W'(1);
            end
            valid_d[req_idx] = 1'b1;
            ram_we           = 1'b1;
          end
        end
        ACT_DELETE: begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          if (!id_ok) begin
            out_d.status = ST_BAD_ID;
          end else begin
            out_d.status = ST_OK;
            if (valid_q[req_idx] && (count_q != '0)) begin
              count_d = count_q - CNT_W'(1);
            end
            valid_d[req_idx] = 1'b0;
          end
        end
        ACT_TICK: begin
        end
        ACT_QUERY: begin
        end
      endcase
    end

    // Advance the tick scan: read one entry, compare the previous one
    if (cmd_i.scan_run && !scan_hold) begin
      if (issue_q < CNT_W'(NUM_SLOTS)) begin
        ram_re      = 1'b1;
        cmp_valid_d = 1'b1;
        cmp_idx_d   = issue_q[SLOT_W-1:0];
        issue_d     = issue_q + CNT_W'(1);
      end else begin
        cmp_valid_d = 1'b0;
      end
      if (cmp_hit) begin
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
        end
        pend_valid_d = 1'b1;
        pend_d       = hit_rsp;
      end
    end

    // Drop the final pending hit into the output, marked last
    if (cmd_i.flush && pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end

    // Step the free-index search
    if (cmd_i.search_run) begin
      if (srch_end) begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d              = qry_rsp;
          stat_o.search_done = 1'b1;
        end
      end else begin
        srch_d = srch_q + SLOT_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      issue_q      <= '0;
      cmp_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      count_q      <= count_d;
      issue_q      <= issue_d;
      cmp_valid_q  <= cmp_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_id_q  <= req_id_d;
    req_now_q <= req_now_d;
    cmp_idx_q <= cmp_idx_d;
    srch_q    <= srch_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/timed_event_table_core.sv =====
// Timed event table: top level joining controller and datapath.
//
// The input channel carries one request per handshake (in_valid_i / in_stall_o):
// create, delete, tick or query. The output channel (out_valid_o / out_stall_i)
// returns result items from a single output register; the last item of each
// request has its last bit set.
// The result of a create or delete is shown in the cycle after it is taken.
// A tick reads the entry memory one entry per cycle unless a hit waits for the
// output register: it accepts the request, streams the 64 entries through the
// memory read and the compare, sees the scan end and releases the final hit.
// Every matching entry gives one result, in index order; a tick with no
// match gives none. A query walks the valid marks up to the lowest free index,
// or to the last index when none is free. The next request is taken once the
// block is idle again and the output register is free or being drained.
// Reset clears all valid marks, the live count and the output valid flag; the
// block accepts requests as soon as reset is released, with no clearing pass.
// While the receiver stalls, the result is held and a tick scan pauses as soon
// as a hit finds an earlier hit pending and the output register still occupied.
module timed_event_table_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tet_pkg::tet_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tet_pkg::tet_rsp_t out_data_o
);
  import tet_pkg::*;

  tet_cmd_t  cmd;
  tet_stat_t stat;

  tet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_data_i.action),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tet_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/tet_checker.sv =====
// Port-level checks of the timed event table and their binding.
module tet_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input tet_pkg::tet_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tet_pkg::tet_rsp_t out_data_o
);
  import tet_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Create and delete answer in the next cycle with a single item
  a_cd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.action == ACT_CREATE || in_data_i.action == ACT_DELETE)
    |=> out_valid_o && out_data_o.last)
    else $error("create or delete result missing");

  // A failed request gives exactly one item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.last)
    else $error("error result not marked last");

  // Fired items carry success and no query fields
  a_fire_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.start_fired || out_data_o.stop_fired)
    |-> out_data_o.status == ST_OK && !out_data_o.free_found &&
        !out_data_o.is_registered)
    else $error("fired result carries wrong fields");

  // A tick keeps the block busy while it scans
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.action == ACT_TICK |=> in_stall_o)
    else $error("request taken during tick scan");

endmodule

bind timed_event_table_core tet_checker u_tet_checker (.*);
